>>> hdl/wsd_pkg.sv
package wsd_pkg;

   localparam int ByteWidth   = 8;
   localparam int TypeWidth   = 4;
   localparam int StatusWidth = 3;
   localparam int PhaseWidth  = 3;
   localparam int CountWidth  = 4;
   localparam int LengthWidth = 64;
   localparam int KeyWidth    = 32;
   localparam int CodeWidth   = 7;

   // Parse phases
   localparam logic [PhaseWidth-1:0] PH_HEAD0   = 3'd0;
   localparam logic [PhaseWidth-1:0] PH_HEAD1   = 3'd1;
   localparam logic [PhaseWidth-1:0] PH_EXTLEN  = 3'd2;
   localparam logic [PhaseWidth-1:0] PH_MASK    = 3'd3;
   localparam logic [PhaseWidth-1:0] PH_PAYLOAD = 3'd4;

   // Length codes that announce an extended length
   localparam logic [CodeWidth-1:0] LEN_EXT16 = 7'd126;
   localparam logic [CodeWidth-1:0] LEN_EXT64 = 7'd127;

   // Extended length and mask key sizes in bytes
   localparam logic [CountWidth-1:0] EXT16_BYTES = 4'd2;
   localparam logic [CountWidth-1:0] EXT64_BYTES = 4'd8;
   localparam logic [CountWidth-1:0] KEY_BYTES   = 4'd4;

   // Opcodes
   localparam logic [TypeWidth-1:0] OP_CONT  = 4'h0;
   localparam logic [TypeWidth-1:0] OP_CLOSE = 4'h8;
   localparam logic [TypeWidth-1:0] OP_PING  = 4'h9;
   localparam logic [TypeWidth-1:0] OP_PONG  = 4'hA;

   // End status codes
   localparam logic [StatusWidth-1:0] ST_DATA  = 3'd0;
   localparam logic [StatusWidth-1:0] ST_STRAY = 3'd1;
   localparam logic [StatusWidth-1:0] ST_CLOSE = 3'd2;
   localparam logic [StatusWidth-1:0] ST_PING  = 3'd3;
   localparam logic [StatusWidth-1:0] ST_PONG  = 3'd4;

   typedef struct packed {
      logic [ByteWidth-1:0]   payload_byte;
      logic                   byte_valid;
      logic [TypeWidth-1:0]   message_type;
      logic                   frame_end;
      logic                   message_end;
      logic [StatusWidth-1:0] end_status;
   } result_type;

   function automatic logic [StatusWidth-1:0] status_of_type(input logic [TypeWidth-1:0] op);
      logic [StatusWidth-1:0] st;
      case (op)
         OP_CONT:  st = ST_STRAY;
         OP_CLOSE: st = ST_CLOSE;
         OP_PING:  st = ST_PING;
         OP_PONG:  st = ST_PONG;
         default:  st = ST_DATA;
      endcase
      return st;
   endfunction

endpackage

>>> hdl/wsd_if.sv
interface wsd_req_if;
   logic                          valid;
   logic                          ready;
   logic [wsd_pkg::ByteWidth-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface wsd_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [wsd_pkg::ByteWidth-1:0]   payload_byte;
   logic                            byte_valid;
   logic [wsd_pkg::TypeWidth-1:0]   message_type;
   logic                            frame_end;
   logic                            message_end;
   logic [wsd_pkg::StatusWidth-1:0] end_status;

   modport source (output valid, output payload_byte, output byte_valid,
                   output message_type, output frame_end, output message_end,
                   output end_status, input ready);
   modport sink   (input valid, input payload_byte, input byte_valid,
                   input message_type, input frame_end, input message_end,
                   input end_status, output ready);
endinterface

>>> hdl/wsd_parser.sv
module wsd_parser (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step_en,
   input  logic [wsd_pkg::ByteWidth-1:0] rx_byte,
   output logic                          res_valid,
   output wsd_pkg::result_type           res
);

   logic [wsd_pkg::PhaseWidth-1:0]  phase_ff, phase_in;
   logic [wsd_pkg::CountWidth-1:0]  count_ff, count_in;
   logic                            fin_ff, fin_in;
   logic                            masked_ff, masked_in;
   logic [wsd_pkg::CodeWidth-1:0]   code_ff, code_in;
   logic [wsd_pkg::LengthWidth-1:0] remain_ff, remain_in;
   logic [wsd_pkg::KeyWidth-1:0]    key_ff, key_in;
   logic [1:0]                      pos_ff, pos_in;
   logic [wsd_pkg::TypeWidth-1:0]   type_ff, type_in;

   logic [wsd_pkg::CountWidth-1:0]  count_inc;
   logic [wsd_pkg::LengthWidth-1:0] remain_dec;
   logic [wsd_pkg::ByteWidth-1:0]   key_byte;
   logic                            fend;

   assign count_inc  = count_ff + 4'd1;
   assign remain_dec = remain_ff - 64'd1;

   always_comb begin
      case (pos_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      fin_in    = fin_ff;
      masked_in = masked_ff;
      code_in   = code_ff;
      remain_in = remain_ff;
      key_in    = key_ff;
      pos_in    = pos_ff;
      type_in   = type_ff;
      res_valid = 1'b0;
      fend      = 1'b0;
      res.payload_byte = '0;
      res.byte_valid   = 1'b0;

      case (phase_ff)
         wsd_pkg::PH_HEAD1: begin
            masked_in = rx_byte[7];
            code_in   = rx_byte[6:0];
            count_in  = '0;
            if (rx_byte[6:0] == wsd_pkg::LEN_EXT16 || rx_byte[6:0] == wsd_pkg::LEN_EXT64) begin
               remain_in = '0;
               phase_in  = wsd_pkg::PH_EXTLEN;
            end else begin
               remain_in = {57'd0, rx_byte[6:0]};
               if (rx_byte[7]) begin
                  phase_in = wsd_pkg::PH_MASK;
               end else begin
                  pos_in = '0;
                  if (rx_byte[6:0] == '0) begin
                     phase_in  = wsd_pkg::PH_HEAD0;
                     res_valid = 1'b1;
                     fend      = 1'b1;
                  end else begin
                     phase_in = wsd_pkg::PH_PAYLOAD;
                  end
               end
            end
         end
         wsd_pkg::PH_EXTLEN: begin
            remain_in = {remain_ff[wsd_pkg::LengthWidth-9:0], rx_byte};
            count_in  = count_inc;
            if (count_inc >= ((code_ff == wsd_pkg::LEN_EXT16) ?
                              wsd_pkg::EXT16_BYTES : wsd_pkg::EXT64_BYTES)) begin
               count_in = '0;
               if (masked_ff) begin
                  phase_in = wsd_pkg::PH_MASK;
               end else begin
                  pos_in = '0;
                  if (remain_in == '0) begin
                     phase_in  = wsd_pkg::PH_HEAD0;
                     res_valid = 1'b1;
                     fend      = 1'b1;
                  end else begin
                     phase_in = wsd_pkg::PH_PAYLOAD;
                  end
               end
            end
         end
         wsd_pkg::PH_MASK: begin
            key_in   = {key_ff[wsd_pkg::KeyWidth-9:0], rx_byte};
            count_in = count_inc;
            if (count_inc >= wsd_pkg::KEY_BYTES) begin
               count_in = '0;
               pos_in   = '0;
               if (remain_ff == '0) begin
                  phase_in  = wsd_pkg::PH_HEAD0;
                  res_valid = 1'b1;
                  fend      = 1'b1;
               end else begin
                  phase_in = wsd_pkg::PH_PAYLOAD;
               end
            end
         end
         wsd_pkg::PH_PAYLOAD: begin
            pos_in    = pos_ff + 2'd1;
            remain_in = remain_dec;
            fend      = (remain_dec == '0);
            if (fend) begin
               phase_in = wsd_pkg::PH_HEAD0;
            end
            res_valid        = 1'b1;
            res.byte_valid   = 1'b1;
            res.payload_byte = masked_ff ? (rx_byte ^ key_byte) : rx_byte;
         end
         default: begin
            fin_in = rx_byte[7];
            if (rx_byte[3:0] != '0) begin
               type_in = rx_byte[3:0];
            end
            count_in = '0;
            phase_in = wsd_pkg::PH_HEAD1;
         end
      endcase

      res.message_type = type_ff;
      res.frame_end    = fend;
      res.message_end  = fend & fin_ff;
      res.end_status   = (fend & fin_ff) ? wsd_pkg::status_of_type(type_ff) : wsd_pkg::ST_DATA;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= wsd_pkg::PH_HEAD0;
         count_ff  <= '0;
         fin_ff    <= 1'b0;
         masked_ff <= 1'b0;
         code_ff   <= '0;
         remain_ff <= '0;
         key_ff    <= '0;
         pos_ff    <= '0;
         type_ff   <= '0;
      end else if (step_en) begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         fin_ff    <= fin_in;
         masked_ff <= masked_in;
         code_ff   <= code_in;
         remain_ff <= remain_in;
         key_ff    <= key_in;
         pos_ff    <= pos_in;
         type_ff   <= type_in;
      end
   end

endmodule

>>> hdl/websocket_frame_deframer.sv
// A request accepted into the input register is parsed into the result register and shows
// on rsp_chan from there. Throughput: one received byte per cycle unless a waiting result
// stalls on the consumer; the parse state register loop sets that figure.
// Header bytes give no result, except the last header byte of a zero-length frame.
// Reset (synchronous, active high) returns the parser to the first header byte,
// clears all parse state and empties the input and result registers.
module websocket_frame_deframer (
   input  logic      clock,
   input  logic      reset,
   wsd_req_if.sink   req_chan,
   wsd_rsp_if.source rsp_chan
);

   // Input register: holds one request for the parser
   logic                          in_valid_ff;
   logic [wsd_pkg::ByteWidth-1:0] in_byte_ff;

   // Result register: parts the parser from the consumer
   logic                          out_valid_ff;
   wsd_pkg::result_type           out_ff;

   logic                          res_valid;
   wsd_pkg::result_type           res;
   logic                          advance;
   logic                          step_en;

   // Advance the held request when it makes no result or the result slot frees up.
   assign advance         = ~res_valid | ~out_valid_ff | rsp_chan.ready;
   assign step_en         = in_valid_ff & advance;
   assign req_chan.ready  = ~in_valid_ff | advance;

   wsd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step_en   (step_en),
      .rx_byte   (in_byte_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   // Capture the request byte only on acceptance.
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff <= req_chan.rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step_en && res_valid) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   // Load a new result; otherwise hold the waiting one.
   always_ff @(posedge clock) begin
      if (step_en && res_valid) begin
         out_ff <= res;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.payload_byte = out_ff.payload_byte;
   assign rsp_chan.byte_valid   = out_ff.byte_valid;
   assign rsp_chan.message_type = out_ff.message_type;
   assign rsp_chan.frame_end    = out_ff.frame_end;
   assign rsp_chan.message_end  = out_ff.message_end;
   assign rsp_chan.end_status   = out_ff.end_status;

endmodule

>>> hdl/wsd_checker.sv
module wsd_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [wsd_pkg::ByteWidth-1:0]   payload_byte,
   input logic                            byte_valid,
   input logic                            frame_end,
   input logic                            message_end,
   input logic [wsd_pkg::StatusWidth-1:0] end_status
);

   // A result waiting on the consumer keeps its payload.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(payload_byte) && $stable(frame_end))
      else $error("stalled result changed");

   // A result without a payload byte is only ever a zero-length frame end.
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !byte_valid |-> frame_end && payload_byte == '0)
      else $error("empty result is not a frame end");

   // Message end only comes with frame end, and status is zero otherwise.
   a_mend: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!message_end || frame_end) &&
                    (message_end || end_status == wsd_pkg::ST_DATA))
      else $error("message end or status inconsistent");

   // Reset empties the result register.
   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .payload_byte (rsp_chan.payload_byte),
   .byte_valid   (rsp_chan.byte_valid),
   .frame_end    (rsp_chan.frame_end),
   .message_end  (rsp_chan.message_end),
   .end_status   (rsp_chan.end_status)
);
